// ----- rtl/task_scheduler_priority_queue_core_macros.svh -----
// Assertion macros for the checker file of the task scheduler.
// No dependencies; included by bare file name.
`ifndef TASK_SCHEDULER_PRIORITY_QUEUE_CORE_MACROS_SVH
`define TASK_SCHEDULER_PRIORITY_QUEUE_CORE_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define TSQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication between a condition and its consequence in the same cycle.
`define TSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `TSQ_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- rtl/tsq_pkg.sv -----
// Package of the task scheduler: sizes, command and status codes, payload types.
// No dependencies; used by the top level, the queue cell and the checker.
package tsq_pkg;

    localparam int TASK_SLOTS  = 64;
    localparam int STACK_DEPTH = 64;
    localparam int SLOT_AW     = $clog2(TASK_SLOTS);
    localparam int SLOT_CW     = $clog2(TASK_SLOTS + 1);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
    localparam int TOTAL_W     = 22;
    localparam int QLEN_W      = 7;

    // Command codes carried in the mode field.
    localparam logic [2:0] MODE_REGISTER = 3'd0;
    localparam logic [2:0] MODE_REMOVE   = 3'd1;
    localparam logic [2:0] MODE_CHANGE   = 3'd2;
    localparam logic [2:0] MODE_DISPATCH = 3'd3;
    localparam logic [2:0] MODE_LOOKUP   = 3'd4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_BAD_PRIO  = 3'd5
    } t_status;

    // Input transaction, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] memory_mb;
        logic [1:0]  priority_req;
        logic [15:0] task_id;
        logic [2:0]  mode;
    } t_cmd;

    // Result transaction, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]         pad;
        logic [QLEN_W-1:0]  queue_length;
        logic [TOTAL_W-1:0] total_used;
        logic [15:0]        freed_amount;
        logic [15:0]        freed_owner;
        logic               freed_valid;
        logic [15:0]        result_memory;
        logic [1:0]         result_priority;
        logic [15:0]        result_id;
        t_status            status;
    } t_result;

    // Task table entry and memory stack block.
    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  prio;
        logic [15:0] mem;
    } t_slot;

    typedef struct packed {
        logic [15:0] owner;
        logic [15:0] amount;
    } t_block;

    // Operation broadcast to every cell of the ready queue.
    typedef enum logic [1:0] {
        Q_NOP,
        Q_INSERT,
        Q_REMOVE
    } t_q_kind;

    typedef struct packed {
        t_q_kind     kind;
        logic [15:0] id;
        logic [1:0]  prio;
    } t_q_op;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [1:0]  prio;
        logic        ahead;
        logic        shift;
    } t_cell_link;

endpackage

// ----- rtl/task_scheduler_priority_queue_core.sv -----
// Top level of the task scheduler: task table, ready queue of cells, memory stack.
// Depends on tsq_pkg, tsq_ram and tsq_cell.
//
//  Channel  | Direction | Content
//  s_axis   | in        | command: mode, task_id, priority_req, memory_mb
//  m_axis   | out       | one result per command: status, ids, freed block, totals
//
// Register, remove, change priority and lookup scan the task table one slot per cycle
// through its RAM read port; the next command is taken only after the scan is done,
// and a priority change also passes through S_INSERT. Dispatch goes through S_POP,
// then S_POP_WAIT if a stack block is freed, then S_DONE; all queue cells move together.
// Reset is synchronous and clears valid bits, counters and the output valid flag.
// A command is taken only while no other is in work; a result held by a stalled
// output waits in the output register while the next command is accepted.
module task_scheduler_priority_queue_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[2:0], task_id[18:3], priority_req[20:19], memory_mb[36:21], zeros
    input  logic [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], result_id[18:3], result_priority[20:19], result_memory[36:21],
    // freed_valid[37], freed_owner[53:38], freed_amount[69:54], total_used[91:70],
    // queue_length[98:92], zeros
    output logic [103:0] m_axis_tdata
);
    import tsq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_INSERT,
        S_POP,
        S_POP_WAIT,
        S_DONE
    } t_state;

    t_state               r_state;
    t_cmd                 w_cmd;
    t_cmd                 r_cmd;
    t_result              r_out;
    t_result              w_res;
    logic                 r_out_valid;
    logic [TASK_SLOTS-1:0] r_slot_valid;
    logic [SLOT_CW-1:0]   r_qcnt;
    logic [STACK_CW-1:0]  r_sp;
    logic [STACK_CW-1:0]  w_sp_dec;
    logic [TOTAL_W-1:0]   r_total;
    logic                 w_bad_prio;

    // Table scan.
    logic [SLOT_CW-1:0]   r_scan_idx;
    logic                 r_chk_vld;
    logic [SLOT_AW-1:0]   r_chk_idx;
    logic                 r_found;
    logic [SLOT_AW-1:0]   r_fidx;
    logic [1:0]           r_fprio;
    logic [15:0]          r_fmem;
    logic                 r_free_ok;
    logic [SLOT_AW-1:0]   r_free_idx;
    logic                 w_scan_more;
    logic                 w_reg_ok;

    // Result being built.
    t_status              r_res_status;
    logic [15:0]          r_res_id;
    logic [1:0]           r_res_prio;
    logic [15:0]          r_res_mem;
    logic                 r_res_fv;
    logic [15:0]          r_res_fo;
    logic [15:0]          r_res_fa;

    // RAM ports.
    logic                 w_tab_we;
    logic [SLOT_AW-1:0]   w_tab_waddr;
    t_slot                w_tab_wdata;
    t_slot                w_tab_q;
    logic                 w_stk_we;
    t_block               w_stk_wdata;
    t_block               w_stk_q;

    // Queue cells.
    t_q_op                w_q_op;
    t_cell_link           w_link [TASK_SLOTS];
    t_cell_link           w_edge_left;
    t_cell_link           w_edge_right;

    assign w_cmd         = s_axis_tdata;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign w_sp_dec      = r_sp - 1'b1;
    assign w_scan_more   = (r_scan_idx < SLOT_CW'(TASK_SLOTS));
    assign w_reg_ok      = !r_found && r_free_ok && (r_sp < STACK_CW'(STACK_DEPTH));
    // Register and change priority refuse a zero priority before anything else.
    assign w_bad_prio    = (w_cmd.mode == MODE_REGISTER || w_cmd.mode == MODE_CHANGE) &&
                           (w_cmd.priority_req == 2'd0);

    // Task table and memory stack storage.
    tsq_ram #(.WIDTH($bits(t_slot)), .DEPTH(TASK_SLOTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (w_tab_waddr),
        .i_wdata (w_tab_wdata),
        .i_raddr (r_scan_idx[SLOT_AW-1:0]),
        .o_rdata (w_tab_q)
    );

    tsq_ram #(.WIDTH($bits(t_block)), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (r_sp[STACK_AW-1:0]),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_sp_dec[STACK_AW-1:0]),
        .o_rdata (w_stk_q)
    );

    // The table is written when a register or change command commits, the stack only for a register.
    always_comb begin
        w_tab_we    = 1'b0;
        w_tab_waddr = r_free_idx;
        w_tab_wdata = '{id: r_cmd.task_id, prio: r_cmd.priority_req, mem: r_cmd.memory_mb};
        w_stk_we    = 1'b0;
        w_stk_wdata = '{owner: r_cmd.task_id, amount: r_cmd.memory_mb};
        if (r_state == S_EXEC) begin
            if (r_cmd.mode == MODE_REGISTER && w_reg_ok) begin
                w_tab_we = 1'b1;
                w_stk_we = 1'b1;
            end else if (r_cmd.mode == MODE_CHANGE && r_found) begin
                w_tab_we    = 1'b1;
                w_tab_waddr = r_fidx;
                w_tab_wdata = '{id: r_cmd.task_id, prio: r_cmd.priority_req, mem: r_fmem};
            end
        end
    end

    // Operation broadcast to the queue cells.
    always_comb begin
        w_q_op = '{kind: Q_NOP, id: r_cmd.task_id, prio: r_cmd.priority_req};
        unique case (r_state)
            S_EXEC: begin
                if (r_cmd.mode == MODE_REGISTER && w_reg_ok &&
                    r_qcnt < SLOT_CW'(TASK_SLOTS)) begin
                    w_q_op.kind = Q_INSERT;
                end else if ((r_cmd.mode == MODE_REMOVE || r_cmd.mode == MODE_CHANGE) &&
                             r_found) begin
                    w_q_op.kind = Q_REMOVE;
                end
            end
            S_INSERT: begin
                if (r_qcnt < SLOT_CW'(TASK_SLOTS)) begin
                    w_q_op.kind = Q_INSERT;
                end
            end
            S_POP: begin
                if (r_qcnt != '0) begin
                    w_q_op.kind = Q_REMOVE;
                    w_q_op.id   = w_link[0].id;
                end
            end
            default: begin
            end
        endcase
    end

    // Row of queue cells, head at index zero.
    assign w_edge_left  = '{valid: 1'b0, id: '0, prio: '0, ahead: 1'b1, shift: 1'b0};
    assign w_edge_right = '{valid: 1'b0, id: '0, prio: '0, ahead: 1'b0, shift: 1'b0};

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;
        if (g == 0) begin : g_first
            assign w_left = w_edge_left;
        end else begin : g_inner_l
            assign w_left = w_link[g-1];
        end
        if (g == TASK_SLOTS - 1) begin : g_last
            assign w_right = w_edge_right;
        end else begin : g_inner_r
            assign w_right = w_link[g+1];
        end
        tsq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_q_op),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
    end

    // Result assembled from the current totals.
    always_comb begin
        w_res                 = '0;
        w_res.status          = r_res_status;
        w_res.result_id       = r_res_id;
        w_res.result_priority = r_res_prio;
        w_res.result_memory   = r_res_mem;
        w_res.freed_valid     = r_res_fv;
        w_res.freed_owner     = r_res_fo;
        w_res.freed_amount    = r_res_fa;
        w_res.total_used      = r_total;
        w_res.queue_length    = QLEN_W'(r_qcnt);
    end

    // Command sequencer, counters and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_slot_valid <= '0;
            r_qcnt       <= '0;
            r_sp         <= '0;
            r_total      <= '0;
            r_chk_vld    <= 1'b0;
        end else begin
            // The output register empties unless a new result is loaded in the same cycle.
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            if (w_q_op.kind == Q_INSERT) begin
                r_qcnt <= r_qcnt + 1'b1;
            end else if (w_q_op.kind == Q_REMOVE && w_link[TASK_SLOTS-1].shift) begin
                r_qcnt <= r_qcnt - 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd        <= w_cmd;
                        r_res_status <= w_bad_prio ? ST_BAD_PRIO : ST_OK;
                        r_res_id     <= '0;
                        r_res_prio   <= '0;
                        r_res_mem    <= '0;
                        r_res_fv     <= 1'b0;
                        r_res_fo     <= '0;
                        r_res_fa     <= '0;
                        r_found      <= 1'b0;
                        r_free_ok    <= 1'b0;
                        r_scan_idx   <= '0;
                        r_chk_vld    <= 1'b0;
                        case (w_cmd.mode)
                            MODE_REGISTER, MODE_CHANGE: begin
                                r_state <= w_bad_prio ? S_DONE : S_SCAN;
                            end
                            MODE_REMOVE, MODE_LOOKUP: r_state <= S_SCAN;
                            MODE_DISPATCH:            r_state <= S_POP;
                            default:                  r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    // Read one slot a cycle; compare the one read in the cycle before.
                    if (w_scan_more) begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                    r_chk_vld <= w_scan_more;
                    r_chk_idx <= r_scan_idx[SLOT_AW-1:0];
                    if (r_chk_vld) begin
                        if (r_slot_valid[r_chk_idx] && w_tab_q.id == r_cmd.task_id &&
                            !r_found) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_chk_idx;
                            r_fprio <= w_tab_q.prio;
                            r_fmem  <= w_tab_q.mem;
                        end
                        if (!r_slot_valid[r_chk_idx] && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_chk_idx;
                        end
                    end else if (!w_scan_more) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // A found task whose priority changes is queued again next cycle.
                    r_state <= (r_cmd.mode == MODE_CHANGE && r_found) ? S_INSERT : S_DONE;
                    case (r_cmd.mode)
                        MODE_REGISTER: begin
                            if (r_found) begin
                                r_res_status <= ST_DUPLICATE;
                            end else if (!w_reg_ok) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_slot_valid[r_free_idx] <= 1'b1;
                                r_sp    <= r_sp + 1'b1;
                                r_total <= r_total + TOTAL_W'(r_cmd.memory_mb);
                            end
                        end
                        MODE_REMOVE: begin
                            if (!r_found) begin
                                r_res_status <= ST_NOT_FOUND;
                            end else begin
                                r_slot_valid[r_fidx] <= 1'b0;
                            end
                        end
                        MODE_CHANGE: begin
                            if (!r_found) begin
                                r_res_status <= ST_NOT_FOUND;
                            end
                        end
                        MODE_LOOKUP: begin
                            if (!r_found) begin
                                r_res_status <= ST_NOT_FOUND;
                            end else begin
                                r_res_id   <= r_cmd.task_id;
                                r_res_prio <= r_fprio;
                                r_res_mem  <= r_fmem;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_INSERT: begin
                    r_state <= S_DONE;
                end
                S_POP: begin
                    if (r_qcnt == '0) begin
                        r_res_status <= ST_EMPTY;
                        r_state      <= S_DONE;
                    end else begin
                        r_res_id   <= w_link[0].id;
                        r_res_prio <= w_link[0].prio;
                        if (r_sp != '0) begin
                            r_sp    <= w_sp_dec;
                            r_state <= S_POP_WAIT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_POP_WAIT: begin
                    r_res_fv <= 1'b1;
                    r_res_fo <= w_stk_q.owner;
                    r_res_fa <= w_stk_q.amount;
                    r_total  <= r_total - TOTAL_W'(w_stk_q.amount);
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out       <= w_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/tsq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tsq_cell.sv -----
// One cell of the ready queue: holds one entry, shifts toward or away from the head.
// Depends on tsq_pkg.
module tsq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsq_pkg::t_q_op     i_op,
    input  tsq_pkg::t_cell_link i_left,
    input  tsq_pkg::t_cell_link i_right,
    output tsq_pkg::t_cell_link o_link
);
    import tsq_pkg::*;

    logic        r_valid;
    logic [15:0] r_id;
    logic [1:0]  r_prio;
    logic        w_ahead;
    logic        w_hit;
    logic        w_shift;

    // This entry stays ahead of a new one of equal or lower priority.
    assign w_ahead = r_valid && (r_prio >= i_op.prio);
    // Once the removed id is seen, every cell from there on pulls from the right.
    assign w_hit   = r_valid && (r_id == i_op.id);
    assign w_shift = i_left.shift || w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_op.kind)
                Q_INSERT: begin
                    if (!w_ahead) begin
                        if (i_left.ahead) begin
                            r_valid <= 1'b1;
                            r_id    <= i_op.id;
                            r_prio  <= i_op.prio;
                        end else begin
                            r_valid <= i_left.valid;
                            r_id    <= i_left.id;
                            r_prio  <= i_left.prio;
                        end
                    end
                end
                Q_REMOVE: begin
                    if (w_shift) begin
                        r_valid <= i_right.valid;
                        r_id    <= i_right.id;
                        r_prio  <= i_right.prio;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.id    = r_id;
    assign o_link.prio  = r_prio;
    assign o_link.ahead = w_ahead;
    assign o_link.shift = w_shift;

endmodule

// ----- rtl/tsq_checker.sv -----
// Port-level checker of the task scheduler, bound to the top level.
// Depends on tsq_pkg and task_scheduler_priority_queue_core_macros.svh.
`include "task_scheduler_priority_queue_core_macros.svh"

module tsq_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);
    import tsq_pkg::*;

    t_result w_res;
    assign w_res = m_axis_tdata;

    // A result that is not taken stays offered.
    `TSQ_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, $past(m_axis_tvalid && !m_axis_tready), m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

    // The ready queue never holds more tasks than the table.
    `TSQ_ASSERT_IMPL(a_qlen_range, i_clk, i_rst_n, m_axis_tvalid, w_res.queue_length <= QLEN_W'(TASK_SLOTS), "queue length beyond table size")

    // An empty-queue answer reports an empty queue.
    `TSQ_ASSERT_IMPL(a_empty_len, i_clk, i_rst_n, m_axis_tvalid && w_res.status == ST_EMPTY, w_res.queue_length == '0, "empty status with queued tasks")

    // A freed block only comes with a successful dispatch.
    `TSQ_ASSERT_IMPL(a_freed_ok, i_clk, i_rst_n, m_axis_tvalid && w_res.freed_valid, w_res.status == ST_OK, "freed block on a failed command")

    // A command transaction keeps the input closed in the following cycle.
    `TSQ_ASSERT(a_in_busy, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input ready right after a command")

endmodule

bind task_scheduler_priority_queue_core tsq_checker u_tsq_checker (.*);
